### rtl/tscdp_pkg.sv
// ----------------------------------------------------------------------------
// tscdp_pkg
// Shared widths, the modulus and the modular add of the composition counter.
// ----------------------------------------------------------------------------
package tscdp_pkg;

	localparam int FIELD_W     = 13;
	localparam int WAY_W       = 30;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 32;

	localparam logic [WAY_W-1:0] WAY_MOD = 30'd1000000007;

	// both operands below WAY_MOD, so one conditional subtract suffices
	function automatic logic [WAY_W-1:0] add_mod(input logic [WAY_W-1:0] a,
		input logic [WAY_W-1:0] b);
		logic [WAY_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, WAY_MOD}) begin
			s = s - {1'b0, WAY_MOD};
		end
		return s[WAY_W-1:0];
	endfunction

endpackage

### rtl/tscdp_mem.sv
// ----------------------------------------------------------------------------
// tscdp_mem
// Ways table: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tscdp_mem #(
	parameter int DEPTH = 4097,
	parameter int AW    = 13
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [tscdp_pkg::WAY_W-1:0]   wdata,
	input  logic [AW-1:0]                 raddr_a,
	input  logic [AW-1:0]                 raddr_b,
	output logic [tscdp_pkg::WAY_W-1:0]   rdata_a,
	output logic [tscdp_pkg::WAY_W-1:0]   rdata_b
);

	logic [tscdp_pkg::WAY_W-1:0] ways_mem_q [DEPTH];
	logic [tscdp_pkg::WAY_W-1:0] rdata_a_q;
	logic [tscdp_pkg::WAY_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ways_mem_q[waddr] <= wdata;
		end
	end

	// read-before-write: a same-cycle write is not seen
	always_ff @(posedge clk) begin
		rdata_a_q <= ways_mem_q[raddr_a];
		rdata_b_q <= ways_mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

### rtl/two_step_length_count_dp_core.sv
// ----------------------------------------------------------------------------
// two_step_length_count_dp_core
// Counts compositions of lengths from two block sizes, modulo 1000000007,
// summed over a length range.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata bits (low to high)
//  s_axis   | in  | min_length[12:0] max_length[25:13] step_a[38:26] step_b[51:39]
//  m_axis   | out | way_count[29:0]
//
// An item fills table entries up to max_length (saturated to MAX_LEN) at
// one table entry per cycle, bound by the single write port of the ways table.
// A step of 1 reads the entry written in the same cycle; it is forwarded.
// Reset clears control and the running sum only; the table needs no clearing since every item
// rewrites entries 0..max_length before reading them.
// The input is taken again while a result waits on the output register.
// ----------------------------------------------------------------------------
module two_step_length_count_dp_core #(
	parameter int MAX_LEN = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// min_length, max_length, step_a, step_b, zero pad
	input  logic [tscdp_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// way_count, zero pad
	output logic [tscdp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int DEPTH = MAX_LEN + 1;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = (IW > tscdp_pkg::FIELD_W) ? IW : tscdp_pkg::FIELD_W;
	localparam int FW    = tscdp_pkg::FIELD_W;
	localparam int WW    = tscdp_pkg::WAY_W;

	localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] lo_q, hi_q, sa_q, sb_q, idx_q;
	logic [WW-1:0] sum_q;

	logic          vld_s1, use_a_s1, use_b_s1, fwd_a_s1, fwd_b_s1, inr_s1;
	logic [IW-1:0] idx_s1;
	logic [WW-1:0] fdat_s1;
	logic          vld_s2, inr_s2;
	logic [WW-1:0] v_s2;

	logic          m_tvalid_q;
	logic [WW-1:0] out_q;

	logic [CW-1:0] in_hi, diff_a, diff_b;
	logic          accept, issue, use_a, use_b, fwd_a, fwd_b, out_free, out_load;
	logic [IW-1:0] raddr_a, raddr_b;
	logic          we;
	logic [IW-1:0] waddr;
	logic [WW-1:0] wdata, rd_a, rd_b, op_a, op_b, v;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_hi    = (CW'(s_tdata[2*FW-1:FW]) > MAX_C) ? MAX_C : CW'(s_tdata[2*FW-1:FW]);
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && !vld_s2 && out_free;

	// read issue for entry idx_q
	assign issue  = (state_q == ST_RUN);
	assign diff_a = idx_q - sa_q;
	assign diff_b = idx_q - sb_q;
	assign use_a  = (sa_q != '0) && (sa_q <= idx_q);
	assign use_b  = (sb_q != '0) && (sb_q <= idx_q);
	assign raddr_a = use_a ? diff_a[IW-1:0] : '0;
	assign raddr_b = use_b ? diff_b[IW-1:0] : '0;

	// entry compute from read data or the forwarded write
	assign op_a = !use_a_s1 ? '0 : (fwd_a_s1 ? fdat_s1 : rd_a);
	assign op_b = !use_b_s1 ? '0 : (fwd_b_s1 ? fdat_s1 : rd_b);
	assign v    = tscdp_pkg::add_mod(op_a, op_b);

	always_comb begin
		if (state_q == ST_INIT) begin
			we    = 1'b1;
			waddr = '0;
			wdata = WW'(1);
		end else begin
			we    = vld_s1;
			waddr = idx_s1;
			wdata = v;
		end
	end

	assign fwd_a = we && (raddr_a == waddr);
	assign fwd_b = we && (raddr_b == waddr);

	tscdp_mem #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			m_tvalid_q <= 1'b0;
			sum_q      <= '0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (vld_s2 && inr_s2) begin
				sum_q <= tscdp_pkg::add_mod(sum_q, v_s2);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					sum_q   <= (lo_q == '0) ? WW'(1) : '0;
					state_q <= (hi_q == '0) ? ST_FIN : ST_RUN;
				end
				ST_RUN: begin
					if (idx_q == hi_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= CW'(s_tdata[FW-1:0]);
			hi_q <= in_hi;
			sa_q <= CW'(s_tdata[3*FW-1:2*FW]);
			sb_q <= CW'(s_tdata[4*FW-1:3*FW]);
		end
		if (state_q == ST_INIT) begin
			idx_q <= CW'(1);
		end else if (issue) begin
			idx_q <= idx_q + CW'(1);
		end
		idx_s1   <= idx_q[IW-1:0];
		use_a_s1 <= use_a;
		use_b_s1 <= use_b;
		fwd_a_s1 <= fwd_a;
		fwd_b_s1 <= fwd_b;
		fdat_s1  <= wdata;
		inr_s1   <= (idx_q >= lo_q);
		v_s2     <= v;
		inr_s2   <= inr_s1;
		if (out_load) begin
			out_q <= sum_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(tscdp_pkg::OUT_TDATA_W - WW){1'b0}}, out_q};

endmodule

### bench/two_step_length_count_dp_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_step_length_count_dp_core_tb
// Sends length-range queries and checks every way count against a known
// value or a local table-filling model. A short table of edge cases comes
// first, then random queries, mostly short, with a few long ones that also
// hit saturation. Both handshake sides idle at random, with some stretches
// that run at full rate.
// ----------------------------------------------------------------------------
module two_step_length_count_dp_core_tb;

	localparam int FIELD_W     = tscdp_pkg::FIELD_W;
	localparam int WAY_W       = tscdp_pkg::WAY_W;
	localparam int IN_TDATA_W  = tscdp_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = tscdp_pkg::OUT_TDATA_W;

	localparam logic [WAY_W-1:0] WAY_MOD = tscdp_pkg::WAY_MOD;

	localparam int MAX_LEN      = 4096;
	localparam int PERIOD       = 20;
	localparam int LIMIT        = 2_000_000;
	localparam int RANDOM_ITEMS = 122;
	localparam int DIRECTED_N   = 18;

	typedef struct packed {
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		logic [FIELD_W-1:0] step_a;
		logic [FIELD_W-1:0] step_b;
	} query_t;

	// typed = 1: want is the known count, else the model supplies it
	typedef struct packed {
		query_t             q;
		logic               typed;
		logic [WAY_W-1:0]   want;
	} probe_t;

	localparam probe_t DIRECTED [0:DIRECTED_N-1] = '{
		'{'{13'd0,    13'd0,    13'd0,    13'd0   }, 1'b1, 30'd1   }, // only entry 0
		'{'{13'd1,    13'd0,    13'd1,    13'd1   }, 1'b1, 30'd0   }, // empty range
		'{'{13'd0,    13'd5,    13'd0,    13'd0   }, 1'b1, 30'd1   }, // no usable step
		'{'{13'd1,    13'd5,    13'd0,    13'd0   }, 1'b1, 30'd0   },
		'{'{13'd1,    13'd10,   13'd1,    13'd0   }, 1'b1, 30'd10  }, // all entries one
		'{'{13'd1,    13'd3,    13'd1,    13'd1   }, 1'b1, 30'd14  }, // entries double
		'{'{13'd0,    13'd4096, 13'd8191, 13'd8191}, 1'b1, 30'd1   }, // steps never fit
		'{'{13'd4096, 13'd8191, 13'd4096, 13'd8191}, 1'b1, 30'd1   }, // max saturates
		'{'{13'd4097, 13'd8191, 13'd1,    13'd2   }, 1'b1, 30'd0   }, // min past bound
		'{'{13'd8191, 13'd8191, 13'd8191, 13'd8191}, 1'b1, 30'd0   },
		'{'{13'd5,    13'd5,    13'd5,    13'd5   }, 1'b1, 30'd2   },
		'{'{13'd0,    13'd8191, 13'd0,    13'd1   }, 1'b1, 30'd4097},
		'{'{13'd0,    13'd4096, 13'd1,    13'd2   }, 1'b0, 30'd0   }, // wraps the modulus
		'{'{13'd1,    13'd4096, 13'd1,    13'd1   }, 1'b0, 30'd0   },
		'{'{13'd2,    13'd7,    13'd2,    13'd3   }, 1'b0, 30'd0   },
		'{'{13'd3,    13'd20,   13'd4,    13'd4   }, 1'b0, 30'd0   },
		'{'{13'd100,  13'd4095, 13'd3,    13'd7   }, 1'b0, 30'd0   },
		'{'{13'd1,    13'd2,    13'd2,    13'd1   }, 1'b0, 30'd0   }
	};

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata  = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;

	logic [WAY_W-1:0]        ways_memo [0:MAX_LEN];
	logic [WAY_W-1:0]        want_counts [$];
	logic                    no_idle    = 1'b0;
	int                      errors     = 0;
	int                      sent_count = 0;
	int                      got_count  = 0;
	int                      long_count = 0;
	int                      cycles     = 0;

	two_step_length_count_dp_core #(
		.MAX_LEN (MAX_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(PERIOD/2) clk = ~clk;

	function automatic logic [WAY_W-1:0] wrap_add(input logic [WAY_W-1:0] a,
		input logic [WAY_W-1:0] b);
		logic [WAY_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, WAY_MOD}) ? WAY_W'(s - {1'b0, WAY_MOD}) : s[WAY_W-1:0];
	endfunction

	// fills the ways table up to the saturated max, then sums the range
	function automatic logic [WAY_W-1:0] predict_way_count(input query_t q);
		int unsigned       top;
		int unsigned       i;
		logic [WAY_W-1:0]  acc;
		logic [WAY_W-1:0]  total;
		top = (q.hi > MAX_LEN) ? MAX_LEN : q.hi;
		ways_memo[0] = WAY_W'(1);
		for (i = 1; i <= top; i++) begin
			acc = '0;
			if (q.step_a != 0 && q.step_a <= i) begin
				acc = wrap_add(acc, ways_memo[FIELD_W'(i - q.step_a)]);
			end
			if (q.step_b != 0 && q.step_b <= i) begin
				acc = wrap_add(acc, ways_memo[FIELD_W'(i - q.step_b)]);
			end
			ways_memo[FIELD_W'(i)] = acc;
		end
		total = '0;
		for (i = q.lo; i <= top; i++) begin
			total = wrap_add(total, ways_memo[FIELD_W'(i)]);
		end
		return total;
	endfunction

	task automatic send_query(input query_t q, input logic typed,
		input logic [WAY_W-1:0] want);
		int gap;
		s_tdata  <= IN_TDATA_W'({q.step_b, q.step_a, q.hi, q.lo});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		want_counts.push_back(typed ? want : predict_way_count(q));
		sent_count++;
		gap = no_idle ? 0 : $urandom_range(19, 0);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[two_step_length_count_dp_core] ERROR");
			$finish;
		end
	end

	// result side
	initial begin
		int               stall;
		logic [WAY_W-1:0] want;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(19, 0);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got_count++;
			if (want_counts.size() == 0) begin
				errors++;
				$display("%0t: way_count with none pending: expected none, got %0d",
					$time, m_tdata);
			end else begin
				want = want_counts.pop_front();
				if (m_tdata !== OUT_TDATA_W'(want)) begin
					errors++;
					$display("%0t: way_count mismatch: expected %0d, got %0d",
						$time, want, m_tdata);
				end
			end
		end
	end

	// query side
	initial begin
		query_t rq;
		logic   longq;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIRECTED_N; k++) begin
			send_query(DIRECTED[k].q, DIRECTED[k].typed, DIRECTED[k].want);
		end

		// drain completely before the random part
		s_tvalid <= 1'b0;
		while (want_counts.size() != 0) @(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle = ((n / 20) % 2) == 1;
			longq = ($urandom_range(11, 0) == 0);
			if (longq) begin
				rq.hi = FIELD_W'($urandom_range(8191, 1024));
				long_count++;
			end else begin
				rq.hi = FIELD_W'($urandom_range(80, 0));
			end
			rq.step_a = FIELD_W'(($urandom_range(7, 0) == 0) ? $urandom_range(8191, 0)
				: $urandom_range(12, 0));
			rq.step_b = FIELD_W'(($urandom_range(7, 0) == 0) ? $urandom_range(8191, 0)
				: $urandom_range(12, 0));
			rq.lo = FIELD_W'(($urandom_range(7, 0) == 0) ? $urandom_range(8191, 0)
				: $urandom_range(rq.hi, 0));
			send_query(rq, 1'b0, '0);
		end
		no_idle = 1'b0;
		s_tvalid <= 1'b0;

		while (want_counts.size() != 0) @(posedge clk);
		// a full query time, to catch any stray result
		repeat (MAX_LEN + 64) @(posedge clk);

		$display("covered %0d queries (%0d edge cases, %0d long random), %0d counts seen",
			sent_count, DIRECTED_N, long_count, got_count);
		if (errors == 0) begin
			$display("[two_step_length_count_dp_core] OK");
		end else begin
			$display("[two_step_length_count_dp_core] ERROR");
		end
		$finish;
	end

endmodule

### sim.f
rtl/tscdp_pkg.sv
rtl/tscdp_mem.sv
rtl/two_step_length_count_dp_core.sv
bench/two_step_length_count_dp_core_tb.sv
